// ----- rtl/core/mbc_pkg.sv -----
// Shared types, signature table and a text-byte helper function for the file type classifier.
package mbc_pkg;

  localparam int POS_W       = 10;
  localparam int NUM_SIGS    = 10;
  localparam int SIG_MAX_LEN = 8;
  localparam int SIG_IDX_W   = $clog2(SIG_MAX_LEN);
  localparam int SIG_LEN_W   = $clog2(SIG_MAX_LEN + 1);
  localparam int TEXT_LIMIT_DEF = 512;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef enum logic [3:0] {
    FT_UNKNOWN = 4'd0,
    FT_ELF     = 4'd1,
    FT_PNG     = 4'd2,
    FT_PDF     = 4'd3,
    FT_JPEG    = 4'd4,
    FT_ZIP     = 4'd5,
    FT_PE      = 4'd6,
    FT_MACHO   = 4'd7,
    FT_SCRIPT  = 4'd8,
    FT_TEXT    = 4'd9
  } file_type_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_item;
  } byte_item_t;

  localparam logic [7:0] SIG_PAT [NUM_SIGS][SIG_MAX_LEN] = '{
    '{8'h7F, 8'h45, 8'h4C, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
    '{8'h25, 8'h50, 8'h44, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4D, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hCF, 8'hFA, 8'hED, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFE, 8'hED, 8'hFA, 8'hCF, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hCF, 8'hFA, 8'hED, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h23, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [SIG_LEN_W-1:0] SIG_LEN [NUM_SIGS] = '{
    SIG_LEN_W'(4), SIG_LEN_W'(8), SIG_LEN_W'(4), SIG_LEN_W'(3), SIG_LEN_W'(4),
    SIG_LEN_W'(2), SIG_LEN_W'(4), SIG_LEN_W'(4), SIG_LEN_W'(4), SIG_LEN_W'(2)
  };

  localparam file_type_t SIG_KIND [NUM_SIGS] = '{
    FT_ELF, FT_PNG, FT_PDF, FT_JPEG, FT_ZIP,
    FT_PE, FT_MACHO, FT_MACHO, FT_MACHO, FT_SCRIPT
  };

  // Printable ASCII, tab, LF or CR.
  function automatic logic is_text_byte(input logic [7:0] c);
    logic res;
    res = (c inside {[8'h20:8'h7E]}) || (c inside {8'h09, 8'h0A, 8'h0D});
    return res;
  endfunction

endpackage

// ----- rtl/core/mbc_if.sv -----
// Valid/ready channel interfaces for byte items and file type results.
interface mbc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_item;

  modport source (output valid, data_byte, byte_present, last_item, input ready);
  modport sink   (input valid, data_byte, byte_present, last_item, output ready);
endinterface

interface mbc_type_if;
  logic       valid;
  logic       ready;
  logic [3:0] file_type;

  modport source (output valid, file_type, input ready);
  modport sink   (input valid, file_type, output ready);
endinterface

// ----- rtl/core/mbc_in_stage.sv -----
// Input register stage holding one accepted byte item.
module mbc_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  mbc_byte_if.sink            in_if,
  input  logic                go,
  output logic                s1_valid,
  output mbc_pkg::byte_item_t s1_item
);

  logic                valid_r;
  logic                valid_nxt;
  mbc_pkg::byte_item_t item_r;
  logic                accept;

  assign in_if.ready = !valid_r || go;
  assign accept      = in_if.valid && in_if.ready;
  assign valid_nxt   = accept ? 1'b1 : (go ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte    <= in_if.data_byte;
      item_r.byte_present <= in_if.byte_present;
      item_r.last_item    <= in_if.last_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ----- rtl/core/mbc_core.sv -----
// Signature match state, text check and classification of the final item.
module mbc_core #(
  parameter int TEXT_LIMIT = mbc_pkg::TEXT_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s1_valid,
  input  mbc_pkg::byte_item_t   s1_item,
  input  logic                  out_free,
  output logic                  go,
  output logic                  res_valid,
  output mbc_pkg::file_type_t   res_type
);

  localparam logic [mbc_pkg::POS_W-1:0] TEXT_LIM = mbc_pkg::POS_W'(TEXT_LIMIT);

  logic [mbc_pkg::POS_W-1:0]    pos_r, pos_nxt, pos_upd;
  logic [mbc_pkg::NUM_SIGS-1:0] alive_r, alive_nxt, alive_upd, kill;
  logic                         text_r, text_nxt, text_upd;
  logic                         take;
  logic [mbc_pkg::SIG_IDX_W-1:0] pos_idx;
  mbc_pkg::file_type_t          cls;

  assign go      = s1_valid && (!s1_item.last_item || out_free);
  assign take    = go;
  assign pos_idx = pos_r[mbc_pkg::SIG_IDX_W-1:0];

  always_comb begin
    for (int i = 0; i < mbc_pkg::NUM_SIGS; i++) begin
      kill[i] = s1_item.byte_present &&
                (pos_r < mbc_pkg::POS_W'(mbc_pkg::SIG_LEN[i])) &&
                (s1_item.data_byte != mbc_pkg::SIG_PAT[i][pos_idx]);
    end
  end

  assign alive_upd = alive_r & ~kill;
  assign text_upd  = text_r && !(s1_item.byte_present && (pos_r < TEXT_LIM) &&
                                 !mbc_pkg::is_text_byte(s1_item.data_byte));
  assign pos_upd   = (s1_item.byte_present && (pos_r != mbc_pkg::POS_MAX)) ?
                     pos_r + mbc_pkg::POS_W'(1) : pos_r;

  // Lowest table entry wins.
  always_comb begin
    cls = text_upd ? mbc_pkg::FT_TEXT : mbc_pkg::FT_UNKNOWN;
    for (int i = mbc_pkg::NUM_SIGS - 1; i >= 0; i--) begin
      if (alive_upd[i] && (pos_upd >= mbc_pkg::POS_W'(mbc_pkg::SIG_LEN[i]))) begin
        cls = mbc_pkg::SIG_KIND[i];
      end
    end
    if (pos_upd == '0) begin
      cls = mbc_pkg::FT_UNKNOWN;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    alive_nxt = alive_r;
    text_nxt  = text_r;
    if (take) begin
      if (s1_item.last_item) begin
        pos_nxt   = '0;
        alive_nxt = '1;
        text_nxt  = 1'b1;
      end else begin
        pos_nxt   = pos_upd;
        alive_nxt = alive_upd;
        text_nxt  = text_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      alive_r <= '1;
      text_r  <= 1'b1;
    end else begin
      pos_r   <= pos_nxt;
      alive_r <= alive_nxt;
      text_r  <= text_nxt;
    end
  end

  assign res_valid = take && s1_item.last_item;
  assign res_type  = cls;

endmodule

// ----- rtl/core/mbc_out_stage.sv -----
// Result register driving the file type channel.
module mbc_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  mbc_pkg::file_type_t res_type,
  output logic                out_free,
  mbc_type_if.source          out_if
);

  logic                valid_r, valid_nxt;
  mbc_pkg::file_type_t type_r;

  assign out_free  = !valid_r || out_if.ready;
  assign valid_nxt = res_valid ? 1'b1 : (out_free ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      type_r <= res_type;
    end
  end

  assign out_if.valid     = valid_r;
  assign out_if.file_type = type_r;

endmodule

// ----- rtl/core/magic_byte_file_type_classifier_unit.sv -----
// Magic-byte file type classifier: top level.
// Feed the leading bytes of a file one per item, with last_item set on the final
// item (byte_present may be 0 there, or on an empty file). One item is taken per
// clock; the file type of the final item is held in a result register that lets
// the input keep flowing while it waits. The ten signature compares, the text
// check over the first TEXT_LIMIT bytes and the first-match selection all sit
// between the input register and the result register. Input stalls only when a
// final item meets a full, stalled result register. All state returns to reset
// after each result.
module magic_byte_file_type_classifier_unit #(
  parameter int TEXT_LIMIT = mbc_pkg::TEXT_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  mbc_byte_if.sink   in_if,
  mbc_type_if.source out_if
);

  logic                s1_valid;
  mbc_pkg::byte_item_t s1_item;
  logic                go;
  logic                out_free;
  logic                res_valid;
  mbc_pkg::file_type_t res_type;

  mbc_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .go       (go),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  mbc_core #(.TEXT_LIMIT(TEXT_LIMIT)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .out_free  (out_free),
    .go        (go),
    .res_valid (res_valid),
    .res_type  (res_type)
  );

  mbc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_type  (res_type),
    .out_free  (out_free),
    .out_if    (out_if)
  );

endmodule

// ----- tb/mbc_type_checker.sv -----
`timescale 1ns / 1ps
// Checker for the file type classifier: follows byte items, predicts each file type, compares results.
module mbc_type_checker #(
  parameter int TEXT_LIMIT = mbc_pkg::TEXT_LIMIT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mbc_byte_if  in_ch,
  mbc_type_if  out_ch,
  output int   mismatches,
  output int   types_awaited
);

  localparam int MAGIC_COUNT = 10;
  localparam logic [9:0] HEAD_LEN_MAX = 10'h3FF;

  localparam logic [7:0] MAGIC [MAGIC_COUNT][8] = '{
    '{8'h7F, 8'h45, 8'h4C, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
    '{8'h25, 8'h50, 8'h44, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4D, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hCF, 8'hFA, 8'hED, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFE, 8'hED, 8'hFA, 8'hCF, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hCF, 8'hFA, 8'hED, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h23, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int MAGIC_SIZE [MAGIC_COUNT] = '{4, 8, 4, 3, 4, 2, 4, 4, 4, 2};
  localparam mbc_pkg::file_type_t MAGIC_KIND [MAGIC_COUNT] = '{
    mbc_pkg::FT_ELF, mbc_pkg::FT_PNG, mbc_pkg::FT_PDF, mbc_pkg::FT_JPEG, mbc_pkg::FT_ZIP,
    mbc_pkg::FT_PE, mbc_pkg::FT_MACHO, mbc_pkg::FT_MACHO, mbc_pkg::FT_MACHO,
    mbc_pkg::FT_SCRIPT
  };

  logic [9:0]             head_len;
  logic [MAGIC_COUNT-1:0] magic_live;
  logic                   head_is_text;
  mbc_pkg::file_type_t    expected_types[$];
  mbc_pkg::file_type_t    want;

  function automatic logic printable(input logic [7:0] c);
    return (c >= 8'h20 && c <= 8'h7E) || c == 8'h09 || c == 8'h0A || c == 8'h0D;
  endfunction

  function automatic mbc_pkg::file_type_t head_type();
    if (head_len == 0) return mbc_pkg::FT_UNKNOWN;
    for (int i = 0; i < MAGIC_COUNT; i++) begin
      if (magic_live[i] && head_len >= MAGIC_SIZE[i]) return MAGIC_KIND[i];
    end
    return head_is_text ? mbc_pkg::FT_TEXT : mbc_pkg::FT_UNKNOWN;
  endfunction

  task automatic clear_head();
    head_len     = '0;
    magic_live   = '1;
    head_is_text = 1'b1;
  endtask

  task automatic take_head_byte(input logic [7:0] c);
    for (int i = 0; i < MAGIC_COUNT; i++) begin
      if (head_len < MAGIC_SIZE[i] && c != MAGIC[i][head_len[2:0]]) magic_live[i] = 1'b0;
    end
    if (head_len < TEXT_LIMIT && !printable(c)) head_is_text = 1'b0;
    if (head_len != HEAD_LEN_MAX) head_len = head_len + 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_head();
      expected_types.delete();
      mismatches    <= 0;
      types_awaited <= 0;
    end else begin
      // result first: it can never stem from the item accepted at the same edge
      if (out_ch.valid && out_ch.ready) begin
        if (expected_types.size() == 0) begin
          $display("%0t: file type with none pending: expected none, actual %0d",
                   $time, out_ch.file_type);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_types.pop_front();
          if (out_ch.file_type !== want) begin
            $display("%0t: file_type: expected %0d, actual %0d",
                     $time, want, out_ch.file_type);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.byte_present) take_head_byte(in_ch.data_byte);
        if (in_ch.last_item) begin
          expected_types.push_back(head_type());
          clear_head();
        end
      end
      types_awaited <= expected_types.size();
    end
  end

endmodule

// ----- tb/tb_magic_byte_file_type_classifier_unit.sv -----
`timescale 1ns / 1ps
// Testbench top: drives file heads and result back-pressure into the classifier, gives the verdict.
module tb_magic_byte_file_type_classifier_unit;

  localparam int HEAD_TEXT_LIMIT = mbc_pkg::TEXT_LIMIT_DEF;
  localparam int RANDOM_ITEMS    = 1100;
  localparam int PHASES          = 4;
  localparam int HOLD_CYCLES     = 300;
  localparam int PRESSURE_FILES  = 40;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 16;

  localparam int SEND_IDLE  [PHASES] = '{0, 76, 0, 29};
  localparam int RECV_STALL [PHASES] = '{0, 0, 76, 29};

  localparam logic [7:0] PREFIX [10][8] = '{
    '{8'h7F, 8'h45, 8'h4C, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A},
    '{8'h25, 8'h50, 8'h44, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 8'hD8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h50, 8'h4B, 8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h4D, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hCF, 8'hFA, 8'hED, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hFE, 8'hED, 8'hFA, 8'hCF, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hCF, 8'hFA, 8'hED, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h23, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int PREFIX_LEN [10] = '{4, 8, 4, 3, 4, 2, 4, 4, 4, 2};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   mismatches;
  int   types_awaited;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_req       = 0;
  int   hold_ack;
  int   hold_left;
  int   quiet_cycles   = 0;
  int   items_sent     = 0;
  int   phase_target;

  mbc_byte_if in_ch();
  mbc_type_if out_ch();

  magic_byte_file_type_classifier_unit #(
    .TEXT_LIMIT(HEAD_TEXT_LIMIT)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  mbc_type_checker #(
    .TEXT_LIMIT(HEAD_TEXT_LIMIT)
  ) u_type_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatches    (mismatches),
    .types_awaited (types_awaited)
  );

  always #2 clk = ~clk;

  // result side: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_ack     <= 0;
      hold_left    <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(input logic [7:0] b, input logic present, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= b;
    in_ch.byte_present <= present;
    in_ch.last_item    <= last;
    do @(posedge clk); while (!in_ch.ready);
    if (present || last) items_sent++;
  endtask

  function automatic logic [7:0] text_char();
    case ($urandom_range(15))
      0:       return 8'h09;
      1:       return 8'h0A;
      2:       return 8'h0D;
      default: return 8'($urandom_range(8'h7E, 8'h20));
    endcase
  endfunction

  // sends one file head, ending on its last byte or on a separate end marker
  task automatic send_head(input logic [7:0] head[$]);
    logic marker;
    marker = (head.size() == 0) || ($urandom_range(2) == 0);
    foreach (head[i]) begin
      if ($urandom_range(11) == 0) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(head[i], 1'b1, !marker && i == head.size() - 1);
    end
    if (marker) push_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic send_random_file();
    logic [7:0] head[$];
    int pick;
    int cut;
    int idx;
    pick = $urandom_range(15);
    if (pick < 10) begin
      for (int i = 0; i < PREFIX_LEN[pick]; i++) head.push_back(PREFIX[pick][i]);
      case ($urandom_range(5))
        0: begin
          cut = $urandom_range(PREFIX_LEN[pick] - 1);
          while (head.size() > cut) void'(head.pop_back());
        end
        1: begin
          idx = $urandom_range(PREFIX_LEN[pick] - 1);
          head[idx] = head[idx] ^ (8'h01 << $urandom_range(7));
        end
        default: ;
      endcase
    end else if (pick < 13) begin
      repeat ($urandom_range(12, 1)) head.push_back(text_char());
    end else begin
      repeat ($urandom_range(12)) head.push_back(8'($urandom));
    end
    repeat ($urandom_range(6)) head.push_back($urandom_range(1) ? text_char() : 8'($urandom));
    send_head(head);
  endtask

  // text head with a single non-text byte at bad_at
  task automatic send_long_file(input int len, input int bad_at);
    logic [7:0] head[$];
    for (int i = 0; i < len; i++) begin
      head.push_back(i == bad_at ? (8'h80 | 8'($urandom)) : text_char());
    end
    send_head(head);
  endtask

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.byte_present = 1'b0;
    in_ch.last_item    = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty file
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h7F, 1'b1, 1'b0);
    push_item(8'h45, 1'b1, 1'b0);
    push_item(8'h4C, 1'b1, 1'b0);
    push_item(8'h46, 1'b1, 1'b1);
    // stray item with no byte and no end mark
    push_item(8'hFF, 1'b0, 1'b0);
    // end marker after bytes
    push_item(8'h23, 1'b1, 1'b0);
    push_item(8'h21, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h09, 1'b1, 1'b0);
    push_item(8'h0A, 1'b1, 1'b0);
    push_item(8'h0D, 1'b1, 1'b0);
    push_item(8'h20, 1'b1, 1'b0);
    push_item(8'h7E, 1'b1, 1'b1);
    push_item(8'h7F, 1'b1, 1'b1);
    push_item(8'h1F, 1'b1, 1'b1);
    push_item(8'hFF, 1'b1, 1'b0);
    push_item(8'hD8, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b1);
    push_item(8'h4D, 1'b1, 1'b0);
    push_item(8'h5A, 1'b1, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct <= RECV_STALL[p];
      phase_target   = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < phase_target) send_random_file();
      if (p == 0) begin
        // past the text window, and a saturating byte count
        send_long_file(1030, 700);
        send_long_file(513, 512);
        send_long_file(512, 511);
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    hold_req       <= hold_req + 1;
    repeat (PRESSURE_FILES) send_random_file();

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (types_awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && types_awaited == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/mbc_pkg.sv
rtl/core/mbc_if.sv
rtl/core/mbc_in_stage.sv
rtl/core/mbc_core.sv
rtl/core/mbc_out_stage.sv
rtl/core/magic_byte_file_type_classifier_unit.sv
tb/mbc_type_checker.sv
tb/tb_magic_byte_file_type_classifier_unit.sv
